// ===== hdl/gf3pi_pkg.sv =====
package gf3pi_pkg;

	localparam int MAX_DEGREE = 8;
	localparam int COEF_BITS = 16;

	typedef logic [1:0] dig_t;
	typedef dig_t [MAX_DEGREE:0] poly_t;
	typedef logic [3:0] deg_t;
	typedef logic [2:0] idx_t;

	// verdict codes
	localparam logic [1:0] V_IRRED = 2'd0;
	localparam logic [1:0] V_NOT_MONIC = 2'd1;
	localparam logic [1:0] V_FROB = 2'd2;
	localparam logic [1:0] V_GCD = 2'd3;

	localparam dig_t D_ZERO = 2'd0;
	localparam dig_t D_ONE = 2'd1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul_init;
		logic mul_from_acc;
		logic mul_step;
		idx_t bidx;
		logic store_h;
		logic save_ga;
		logic save_gb;
		logic gcd_load;
		logic gcd_sel;
		logic gcd_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		deg_t n;
		logic monic;
		logic frob_ok;
		logic gcd_done;
		logic coprime;
	} stat_t;

	function automatic dig_t gf_norm(input logic [1:0] d);
		return (d == 2'd3) ? D_ZERO : d;
	endfunction

	function automatic dig_t gf_add(input dig_t a, input dig_t b);
		logic [2:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 3'd3) ? dig_t'(s - 3'd3) : dig_t'(s);
	endfunction

	function automatic dig_t gf_sub(input dig_t a, input dig_t b);
		dig_t nb;
		nb = (b == D_ZERO) ? D_ZERO : dig_t'(2'd3 - b);
		return gf_add(a, nb);
	endfunction

	function automatic dig_t gf_mul(input dig_t a, input dig_t b);
		dig_t r;
		if (a == D_ZERO || b == D_ZERO) begin
			r = D_ZERO;
		end else if (a == b) begin
			r = D_ONE;
		end else begin
			r = 2'd2;
		end
		return r;
	endfunction

	// n / r for the odd prime r dividing n (n up to MAX_DEGREE), zero when there is none
	function automatic deg_t odd_quot(input deg_t n);
		deg_t q;
		case (n)
			4'd3, 4'd5, 4'd7: q = 4'd1;
			4'd6: q = 4'd2;
			default: q = 4'd0;
		endcase
		return q;
	endfunction

endpackage

// ===== hdl/gf3pi_datapath.sv =====
module gf3pi_datapath (
	input logic clk,
	input gf3pi_pkg::cmd_t cmd,
	input logic [3:0] degree,
	input logic [15:0] low_coeffs,
	input logic [1:0] lead_coeff,
	output gf3pi_pkg::stat_t st
);
	import gf3pi_pkg::*;

	poly_t f_q, h_q, a_q, b_q, acc_q, ga_q, gb_q, u_q, v_q;
	deg_t n_q;
	logic monic_q;

	poly_t mul_nxt, gcd_nxt, f_ld, x_poly, g_ld;
	dig_t top, bj, cc, vv;
	deg_t du, dv, sh;
	logic uz, vz;

	always_comb begin
		x_poly = '0;
		x_poly[1] = D_ONE;
	end

	// polynomial from the input fields, leading one at position n
	always_comb begin
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			if (i < 8 && deg_t'(i) < degree) begin
				f_ld[i] = gf_norm(low_coeffs[2*i +: 2]);
			end else if (deg_t'(i) == degree) begin
				f_ld[i] = D_ONE;
			end else begin
				f_ld[i] = D_ZERO;
			end
		end
	end

	// gcd operand: selected power minus x
	always_comb begin
		g_ld = cmd.gcd_sel ? gb_q : ga_q;
		g_ld[1] = gf_sub(cmd.gcd_sel ? gb_q[1] : ga_q[1], D_ONE);
	end

	// one Horner step: acc = acc * x mod f + b[j] * a
	always_comb begin
		top = D_ZERO;
		bj = D_ZERO;
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			if (deg_t'(i) + 4'd1 == n_q) top = acc_q[i];
			if (i < 8 && idx_t'(i) == cmd.bidx) bj = b_q[i];
		end
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			if (deg_t'(i) < n_q) begin
				mul_nxt[i] = gf_add(gf_sub((i == 0) ? D_ZERO : acc_q[(i == 0) ? 0 : i-1],
					gf_mul(top, f_q[i])), gf_mul(bj, a_q[i]));
			end else begin
				mul_nxt[i] = D_ZERO;
			end
		end
	end

	// one Euclid step: cancel the top digit of u, or swap when deg u < deg v
	always_comb begin
		du = '0;
		dv = '0;
		uz = 1'b1;
		vz = 1'b1;
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			if (u_q[i] != D_ZERO) begin
				du = deg_t'(i);
				uz = 1'b0;
			end
			if (v_q[i] != D_ZERO) begin
				dv = deg_t'(i);
				vz = 1'b0;
			end
		end
		cc = gf_mul(u_q[du], v_q[dv]);
		sh = du - dv;
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			vv = D_ZERO;
			for (int j = 0; j <= MAX_DEGREE; j++) begin
				if (deg_t'(j) + sh == deg_t'(i)) vv = v_q[j];
			end
			gcd_nxt[i] = (deg_t'(i) >= sh) ? gf_sub(u_q[i], gf_mul(cc, vv)) : u_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= degree;
			monic_q <= (lead_coeff == 2'd1);
			f_q <= f_ld;
			h_q <= x_poly;
		end
		if (cmd.mul_init) begin
			a_q <= cmd.mul_from_acc ? acc_q : h_q;
			b_q <= h_q;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			acc_q <= mul_nxt;
		end
		if (cmd.store_h) begin
			h_q <= acc_q;
		end
		if (cmd.save_ga) begin
			ga_q <= acc_q;
		end
		if (cmd.save_gb) begin
			gb_q <= acc_q;
		end
		if (cmd.gcd_load) begin
			u_q <= f_q;
			v_q <= g_ld;
		end
		if (cmd.gcd_step) begin
			if (uz || du < dv) begin
				u_q <= v_q;
				v_q <= u_q;
			end else begin
				u_q <= gcd_nxt;
			end
		end
	end

	assign st.n = n_q;
	assign st.monic = monic_q;
	assign st.frob_ok = (h_q == x_poly);
	assign st.gcd_done = vz;
	assign st.coprime = !uz && du == 4'd0;

endmodule

// ===== hdl/gf3pi_ctrl.sv =====
module gf3pi_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input gf3pi_pkg::stat_t st,
	output gf3pi_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output logic [1:0] verdict
);
	import gf3pi_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_MINIT1 = 4'd2;
	localparam logic [3:0] S_MSTEP1 = 4'd3;
	localparam logic [3:0] S_MINIT2 = 4'd4;
	localparam logic [3:0] S_MSTEP2 = 4'd5;
	localparam logic [3:0] S_STORE = 4'd6;
	localparam logic [3:0] S_FROB = 4'd7;
	localparam logic [3:0] S_GLOAD = 4'd8;
	localparam logic [3:0] S_GSTEP = 4'd9;

	logic [3:0] state_q;
	idx_t j_q;
	deg_t k_q;
	logic gsel_q;
	logic done_q;
	logic [1:0] verdict_q;
	deg_t ta, tb;

	// powers whose difference with x enters a gcd
	assign ta = st.n[0] ? 4'd0 : {1'b0, st.n[3:1]};
	assign tb = odd_quot(st.n);

	always_comb begin
		cmd = '0;
		cmd.bidx = j_q;
		cmd.gcd_sel = gsel_q;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_MINIT1: cmd.mul_init = 1'b1;
			S_MINIT2: begin
				cmd.mul_init = 1'b1;
				cmd.mul_from_acc = 1'b1;
			end
			S_MSTEP1, S_MSTEP2: cmd.mul_step = 1'b1;
			S_STORE: begin
				cmd.store_h = 1'b1;
				cmd.save_ga = (k_q == ta);
				cmd.save_gb = (k_q == tb);
			end
			S_GLOAD: cmd.gcd_load = 1'b1;
			S_GSTEP: cmd.gcd_step = !st.gcd_done;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			k_q <= '0;
			gsel_q <= 1'b0;
			done_q <= 1'b0;
			verdict_q <= V_IRRED;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CHECK;
				end
				S_CHECK: begin
					k_q <= 4'd1;
					if (st.n == 4'd0 || st.n > deg_t'(MAX_DEGREE) || !st.monic) begin
						done_q <= 1'b1;
						verdict_q <= V_NOT_MONIC;
						state_q <= S_IDLE;
					end else if (st.n == 4'd1) begin
						done_q <= 1'b1;
						verdict_q <= V_IRRED;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MINIT1;
					end
				end
				S_MINIT1, S_MINIT2: begin
					j_q <= idx_t'(st.n - 4'd1);
					state_q <= (state_q == S_MINIT1) ? S_MSTEP1 : S_MSTEP2;
				end
				S_MSTEP1, S_MSTEP2: begin
					if (j_q == '0) begin
						state_q <= (state_q == S_MSTEP1) ? S_MINIT2 : S_STORE;
					end else begin
						j_q <= j_q - 3'd1;
					end
				end
				S_STORE: begin
					if (k_q == st.n) begin
						state_q <= S_FROB;
					end else begin
						k_q <= k_q + 4'd1;
						state_q <= S_MINIT1;
					end
				end
				S_FROB: begin
					if (!st.frob_ok) begin
						done_q <= 1'b1;
						verdict_q <= V_FROB;
						state_q <= S_IDLE;
					end else if (ta != 4'd0) begin
						gsel_q <= 1'b0;
						state_q <= S_GLOAD;
					end else if (tb != 4'd0) begin
						gsel_q <= 1'b1;
						state_q <= S_GLOAD;
					end else begin
						done_q <= 1'b1;
						verdict_q <= V_IRRED;
						state_q <= S_IDLE;
					end
				end
				S_GLOAD: state_q <= S_GSTEP;
				S_GSTEP: begin
					if (st.gcd_done) begin
						if (!st.coprime) begin
							done_q <= 1'b1;
							verdict_q <= V_GCD;
							state_q <= S_IDLE;
						end else if (!gsel_q && tb != 4'd0) begin
							gsel_q <= 1'b1;
							state_q <= S_GLOAD;
						end else begin
							done_q <= 1'b1;
							verdict_q <= V_IRRED;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign verdict = verdict_q;

endmodule

// ===== hdl/gf3_poly_irreducibility_test.sv =====
// Rabin irreducibility test for one polynomial over GF(3).
// Input: pulse start while busy is low with degree, low_coeffs and
// lead_coeff on the ports; the item is taken at that edge and busy rises.
// Output: done is high for exactly one cycle with verdict and
// is_irreducible valid in that cycle; the receiver cannot stall, so the
// result is simply dropped if not sampled then.
// For degree n >= 2: n rounds of modular products (h squared, then times
// h), one digit of the multiplier per cycle on the shared GF(3)
// multiply-reduce unit, then one Euclid step per cycle for each gcd
// (two gcds for n = 6). Trivial cases (degree 0, 1, above 8, not monic)
// are answered from the check state without products. One item is in work
// at a time; busy drops in the cycle that done is high, so the next item
// may start in that cycle.
// Reset (arst_n low) returns the controller to idle and drops done.
module gf3_poly_irreducibility_test (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [3:0] degree,
	input logic [15:0] low_coeffs,
	input logic [1:0] lead_coeff,
	output logic done,
	output logic is_irreducible,
	output logic [1:0] verdict
);
	import gf3pi_pkg::*;

	cmd_t cmd;
	stat_t st;

	gf3pi_datapath u_dp (
		.clk(clk),
		.cmd(cmd),
		.degree(degree),
		.low_coeffs(low_coeffs),
		.lead_coeff(lead_coeff),
		.st(st)
	);

	gf3pi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.st(st),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.verdict(verdict)
	);

	assign is_irreducible = (verdict == V_IRRED);

endmodule

// ===== test/gf3_poly_irreducibility_checker.sv =====
module gf3_poly_irreducibility_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [3:0] degree,
	input logic [15:0] low_coeffs,
	input logic [1:0] lead_coeff,
	input logic done,
	input logic is_irreducible,
	input logic [1:0] verdict,
	output int fail_count,
	output int pending_count
);
	import gf3pi_pkg::*;

	typedef logic [1:0] gf_t;
	typedef gf_t poly9_t [0:8];

	// expected verdicts in order of acceptance
	logic [1:0] want_mem [0:63];
	int wr_idx, rd_idx;
	int verdict_hist[4];

	function automatic gf_t gadd(gf_t a, gf_t b);
		return gf_t'((a + b) % 3);
	endfunction

	function automatic gf_t gmul(gf_t a, gf_t b);
		return gf_t'((a * b) % 3);
	endfunction

	function automatic gf_t gneg(gf_t a);
		return gf_t'((3 - a) % 3);
	endfunction

	function automatic int poly_top(poly9_t p);
		for (int d = 8; d >= 0; d--) begin
			if (p[d] != 0) return d;
		end
		return -1;
	endfunction

	// a * b mod monic f of degree n
	function automatic poly9_t mulmod(poly9_t a, poly9_t b, poly9_t f, int n);
		gf_t prod[0:16];
		poly9_t res;
		gf_t c;
		for (int i = 0; i <= 16; i++) prod[i] = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				prod[i+j] = gadd(prod[i+j], gmul(a[i], b[j]));
		for (int d = 2*n - 2; d >= n; d--) begin
			c = prod[d];
			if (c != 0)
				for (int i = 0; i <= n; i++)
					prod[d-n+i] = gadd(prod[d-n+i], gneg(gmul(c, f[i])));
		end
		for (int i = 0; i <= 8; i++) res[i] = (i < n) ? prod[i] : 2'd0;
		return res;
	endfunction

	// gcd(f, g) is a nonzero constant
	function automatic bit coprime(poly9_t f, poly9_t g);
		poly9_t u, v, t;
		int dv;
		gf_t c;
		u = f;
		v = g;
		forever begin
			dv = poly_top(v);
			if (dv < 0) break;
			for (int d = poly_top(u); d >= dv; d--) begin
				c = gmul(u[d], v[dv]);
				if (c != 0)
					for (int i = 0; i <= dv; i++)
						u[d-dv+i] = gadd(u[d-dv+i], gneg(gmul(c, v[i])));
			end
			t = u;
			u = v;
			v = t;
		end
		return poly_top(u) == 0;
	endfunction

	function automatic logic [1:0] rabin_verdict(int n, logic [15:0] low, logic [1:0] lead);
		poly9_t f, h[0:8], g, x;
		bit prime;
		if (n < 1 || n > MAX_DEGREE || lead != 2'd1) return V_NOT_MONIC;
		if (n == 1) return V_IRRED;
		for (int i = 0; i <= 8; i++) begin
			f[i] = 0;
			x[i] = (i == 1) ? 2'd1 : 2'd0;
		end
		for (int i = 0; i < n; i++)
			f[i] = (low[2*i +: 2] == 2'd3) ? 2'd0 : low[2*i +: 2];
		f[n] = 1;
		h[0] = x;
		for (int k = 1; k <= n; k++)
			h[k] = mulmod(mulmod(h[k-1], h[k-1], f, n), h[k-1], f, n);
		for (int i = 0; i < n; i++)
			if (h[n][i] != x[i]) return V_FROB;
		for (int r = 2; r <= n; r++) begin
			prime = 1;
			for (int q = 2; q < r; q++) if (r % q == 0) prime = 0;
			if (n % r != 0 || !prime) continue;
			g = h[n / r];
			g[1] = gadd(g[1], 2'd2);
			if (!coprime(f, g)) return V_GCD;
		end
		return V_IRRED;
	endfunction

	assign pending_count = wr_idx - rd_idx;

	// predict on accept, compare on done
	always @(posedge clk or negedge arst_n) begin
		logic [1:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			wr_idx <= 0;
			rd_idx <= 0;
		end else begin
			if (done) begin
				if (rd_idx == wr_idx) begin
					$display("%0t: unexpected result verdict=%0d", $time, verdict);
					fail_count <= fail_count + 1;
				end else begin
					want = want_mem[6'(rd_idx)];
					rd_idx <= rd_idx + 1;
					verdict_hist[want]++;
					if (verdict !== want || is_irreducible !== (want == V_IRRED)) begin
						$display("%0t: mismatch expected verdict=%0d irr=%0d got verdict=%0d irr=%0d",
							$time, want, want == V_IRRED, verdict, is_irreducible);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				want_mem[6'(wr_idx)] <= rabin_verdict(int'(degree), low_coeffs, lead_coeff);
				wr_idx <= wr_idx + 1;
			end
		end
	end

endmodule

// ===== test/gf3_poly_irreducibility_test_tb.sv =====
module gf3_poly_irreducibility_test_tb;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [3:0] degree = 0;
	logic [15:0] low_coeffs = 0;
	logic [1:0] lead_coeff = 0;
	logic busy, done, is_irreducible;
	logic [1:0] verdict;
	int fail_count, pending_count;
	int sent;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	gf3_poly_irreducibility_test dut (.*);

	gf3_poly_irreducibility_checker chk (.*);

	// hold start until taken, then idle a random gap
	task automatic send_poly(logic [3:0] n, logic [15:0] c, logic [1:0] ld);
		int gap;
		start <= 1'b1;
		degree <= n;
		low_coeffs <= c;
		lead_coeff <= ld;
		do @(posedge clk); while (busy);
		sent++;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// corners: degrees 0..15, digit value three, leads 0..3
		for (int d = 0; d <= 15; d++) send_poly(4'(d), 16'hffff, 2'd1);
		send_poly(4'd2, 16'h0000, 2'd0);
		send_poly(4'd2, 16'h0002, 2'd2);
		send_poly(4'd2, 16'h0001, 2'd3);
		send_poly(4'd2, 16'hfff2, 2'd1); // x^2+2: digits above ignored
		send_poly(4'd2, 16'h0001, 2'd1); // x^2+1 irreducible
		send_poly(4'd2, 16'h0000, 2'd1); // x^2 reducible
		send_poly(4'd6, 16'h0000, 2'd1);
		send_poly(4'd8, 16'haaaa, 2'd1);
		drain();
		// random: mostly monic and in range
		for (int i = 0; i < 1000; i++) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8);
			send_poly(4'(n), 16'($urandom),
				2'($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : 1));
			if (i == 500) drain();
		end
		drain();
		start <= 1'b0;
		repeat (300) @(posedge clk);
		$display("Sent %0d polynomials; verdicts seen irr=%0d notmonic=%0d frob=%0d gcd=%0d",
			sent, chk.verdict_hist[0], chk.verdict_hist[1], chk.verdict_hist[2],
			chk.verdict_hist[3]);
		if (fail_count == 0 && pending_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gf3pi_pkg.sv
hdl/gf3pi_datapath.sv
hdl/gf3pi_ctrl.sv
hdl/gf3_poly_irreducibility_test.sv
test/gf3_poly_irreducibility_checker.sv
test/gf3_poly_irreducibility_test_tb.sv
